FILE: sv/audio_fifo_rate_trim_dac_feed_top_macros.svh
// Assertion helpers for the DAC feed block.
`ifndef AUDIO_FIFO_RATE_TRIM_DAC_FEED_TOP_MACROS_SVH
`define AUDIO_FIFO_RATE_TRIM_DAC_FEED_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    localparam int FIFO_DEPTH_DEF = 2048;
    localparam int BURST_DEF      = 8;
    localparam int DAC_BITS_DEF   = 12;

    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 16;
    localparam int FILL_W     = 12;
    localparam int TOTAL_W    = 32;
    localparam int VOL_W      = 9;
    localparam int BYTES_W    = 13;
    localparam int OFS_W      = 8;
    localparam int SOFS_W     = 9;
    localparam int GAIN_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_USER_VOLUME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LOW_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_OFFSET       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_OFFSET      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_HIGH_OFFSET = 3'd7;

    localparam logic [VOL_W-1:0]    USER_VOLUME_RST      = 9'd50;
    localparam logic [PERIOD_W-1:0] NOMINAL_PERIOD_RST   = 16'd2999;
    localparam logic [BYTES_W-1:0]  BUFFER_BYTES_RST     = 13'd4000;
    localparam logic [OFS_W-1:0]    VERY_LOW_OFFSET_RST  = 8'd6;
    localparam logic [OFS_W-1:0]    LOW_OFFSET_RST       = 8'd2;
    localparam logic [SOFS_W-1:0]   HIGH_OFFSET_RST      = 9'h1FE;
    localparam logic [SOFS_W-1:0]   VERY_HIGH_OFFSET_RST = 9'h1FA;
    localparam int                  LAST_DAC_RST         = 2047;

    localparam int VOL_MAX   = 500;
    localparam int GAIN_NUM  = 256;
    localparam int GAIN_DEN  = 100;
    localparam int WM_DEN    = 100;
    localparam int WM_VL     = 10;
    localparam int WM_LO     = 25;
    localparam int WM_HI     = 75;
    localparam int WM_VH     = 90;
    localparam int BYTES_MIN = 1000;
    localparam int BYTES_MAX = 4096;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_REFILL = 1'b1;

    typedef struct packed {
        logic [VOL_W-1:0]           user_volume;
        logic                       correction_off;
        logic [PERIOD_W-1:0]        nominal_period;
        logic [BYTES_W-1:0]         buffer_bytes;
        logic [OFS_W-1:0]           very_low_offset;
        logic [OFS_W-1:0]           low_offset;
        logic signed [SOFS_W-1:0]   high_offset;
        logic signed [SOFS_W-1:0]   very_high_offset;
    } cfg_t;

    typedef struct packed {
        logic                       is_refill;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       message_end;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

`default_nettype wire

FILE: sv/audio_fifo_rate_trim_dac_feed_top.sv
//  Channel   Direction  Handshake                Beat contents
//  s_        in         s_valid / s_ready        action, sample, message_end
//  m_        out        m_valid / m_ready        one DAC code with period, fill and totals
//  cfg_      in         cfg_valid / cfg_ready    register index and write data
//
//  The back end takes a push only when idle; a two-entry queue sits in front of it.
//  A refill trims the period, then makes BURST FIFO reads through the scaling
//  pipeline into a buffer before BURST output beats; an underrun refill skips the reads.
//  The single FIFO read port and the full-burst totals in every beat set this order.
//  Reset is synchronous and active low; the FIFO contents are not cleared.
//  A stalled output holds the back end only while it is emitting a burst.
`timescale 1ns / 1ps
`default_nettype none

`include "audio_fifo_rate_trim_dac_feed_top_macros.svh"

module audio_fifo_rate_trim_dac_feed_top #(
    parameter int FIFO_DEPTH = afr_pkg::FIFO_DEPTH_DEF,
    parameter int BURST      = afr_pkg::BURST_DEF,
    parameter int DAC_BITS   = afr_pkg::DAC_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_action,
    input  wire logic signed [afr_pkg::SAMPLE_W-1:0]  s_sample,
    input  wire logic                                 s_message_end,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [DAC_BITS-1:0]                       m_dac_value,
    output logic [afr_pkg::PERIOD_W-1:0]              m_reload_period,
    output logic                                      m_underrun,
    output logic                                      m_last,
    output logic [afr_pkg::FILL_W-1:0]                m_fill_samples,
    output logic [afr_pkg::TOTAL_W-1:0]               m_clip_low_count,
    output logic [afr_pkg::TOTAL_W-1:0]               m_clip_high_count,
    output logic [afr_pkg::TOTAL_W-1:0]               m_underrun_count,
    output logic [afr_pkg::TOTAL_W-1:0]               m_overflow_count,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [afr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [afr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    afr_pkg::cfg_t  cfg_reg, cfg_next;
    logic           cfg_wr, period_load;
    afr_pkg::hs_t   cmd_hs;
    afr_pkg::cmd_t  cmd;
    logic           cmd_ready;
    logic [afr_pkg::GAIN_W-1:0] gain;

    always_comb begin
        cfg_ready   = 1'b1;
        cfg_wr      = cfg_valid && cfg_ready;
        cfg_next    = cfg_reg;
        period_load = 1'b0;
        if (cfg_wr) begin
            case (cfg_index)
                afr_pkg::REG_USER_VOLUME: begin
                    cfg_next.user_volume = cfg_data[afr_pkg::VOL_W-1:0];
                end
                afr_pkg::REG_CORRECTION_OFF: begin
                    cfg_next.correction_off = cfg_data[0];
                end
                afr_pkg::REG_NOMINAL_PERIOD: begin
                    cfg_next.nominal_period = cfg_data[afr_pkg::PERIOD_W-1:0];
                    period_load             = 1'b1;
                end
                afr_pkg::REG_BUFFER_BYTES: begin
                    cfg_next.buffer_bytes = cfg_data[afr_pkg::BYTES_W-1:0];
                end
                afr_pkg::REG_VERY_LOW_OFFSET: begin
                    cfg_next.very_low_offset = cfg_data[afr_pkg::OFS_W-1:0];
                end
                afr_pkg::REG_LOW_OFFSET: begin
                    cfg_next.low_offset = cfg_data[afr_pkg::OFS_W-1:0];
                end
                afr_pkg::REG_HIGH_OFFSET: begin
                    cfg_next.high_offset = cfg_data[afr_pkg::SOFS_W-1:0];
                end
                afr_pkg::REG_VERY_HIGH_OFFSET: begin
                    cfg_next.very_high_offset = cfg_data[afr_pkg::SOFS_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.user_volume      <= afr_pkg::USER_VOLUME_RST;
            cfg_reg.correction_off   <= 1'b0;
            cfg_reg.nominal_period   <= afr_pkg::NOMINAL_PERIOD_RST;
            cfg_reg.buffer_bytes     <= afr_pkg::BUFFER_BYTES_RST;
            cfg_reg.very_low_offset  <= afr_pkg::VERY_LOW_OFFSET_RST;
            cfg_reg.low_offset       <= afr_pkg::LOW_OFFSET_RST;
            cfg_reg.high_offset      <= afr_pkg::HIGH_OFFSET_RST;
            cfg_reg.very_high_offset <= afr_pkg::VERY_HIGH_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    afr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample      (s_sample),
        .s_message_end (s_message_end),
        .cmd_hs_out    (cmd_hs),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    afr_gain u_gain (
        .aclk_vol_unused_guard (cfg_reg.user_volume),
        .aclk                  (aclk),
        .gain                  (gain)
    );

    afr_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .BURST      (BURST),
        .DAC_BITS   (DAC_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .period_load       (period_load),
        .period_value      (cfg_data[afr_pkg::PERIOD_W-1:0]),
        .gain              (gain),
        .cmd_hs            (cmd_hs),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dac_value       (m_dac_value),
        .m_reload_period   (m_reload_period),
        .m_underrun        (m_underrun),
        .m_last            (m_last),
        .m_fill_samples    (m_fill_samples),
        .m_clip_low_count  (m_clip_low_count),
        .m_clip_high_count (m_clip_high_count),
        .m_underrun_count  (m_underrun_count),
        .m_overflow_count  (m_overflow_count)
    );

    // An underrun burst is only ever issued from a nearly empty FIFO.
    `AFR_ASSERT_SAME(a_underrun_fill, m_valid && m_underrun, m_fill_samples <= 4 * BURST, "underrun with a well filled FIFO")

    // Within a burst the next beat is ready as soon as one is taken.
    `AFR_ASSERT_NEXT(a_burst_gapless, m_valid && m_ready && !m_last, m_valid, "gap inside a burst")

    // Checks that every beat of a burst carries the same period and underrun flag.
    `AFR_ASSERT_NEXT(a_burst_fields, m_valid && m_ready && !m_last, (m_reload_period == $past(m_reload_period)) && (m_underrun == $past(m_underrun)), "burst fields changed")

endmodule

`default_nettype wire

FILE: sv/afr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_action,
    input  wire logic signed [afr_pkg::SAMPLE_W-1:0]  s_sample,
    input  wire logic                                 s_message_end,
    output afr_pkg::hs_t                              cmd_hs_out,
    input  wire logic                                 cmd_ready,
    output afr_pkg::cmd_t                             cmd
);

    localparam int CMDQ_DEPTH = 2;
    localparam int QW         = $clog2(CMDQ_DEPTH + 1);

    afr_pkg::cmd_t  q_reg [CMDQ_DEPTH];
    afr_pkg::cmd_t  in_cmd;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0]  cnt_reg, cnt_next;
    logic           push, pop;

    always_comb begin
        in_cmd.is_refill   = (s_action == afr_pkg::ACT_REFILL);
        in_cmd.sample      = s_sample;
        in_cmd.message_end = s_message_end;

        s_ready          = (cnt_reg != QW'(CMDQ_DEPTH));
        cmd_hs_out.valid = (cnt_reg != '0);
        cmd_hs_out.ready = cmd_ready;
        cmd              = q_reg[rd_ptr_reg];

        push = s_valid && s_ready;
        pop  = cmd_hs_out.valid && cmd_ready;

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/afr_gain.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_gain (
    input  wire logic [afr_pkg::VOL_W-1:0] aclk_vol_unused_guard,
    input  wire logic                      aclk,
    output logic [afr_pkg::GAIN_W-1:0]     gain
);

    // Gain is volume, capped at 500, times 256 / 100, with the division done as a
    // multiply by a reciprocal and one correction step.
    localparam int X_W      = afr_pkg::VOL_W + $clog2(afr_pkg::GAIN_NUM);
    localparam int RECIP_SH = 24;
    localparam int RECIP    = (1 << RECIP_SH) / afr_pkg::GAIN_DEN;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int P_W      = X_W + RECIP_W;

    logic [afr_pkg::VOL_W-1:0]  vol_cap;
    logic [X_W-1:0]             x, x_reg;
    logic [P_W-1:0]             prod_reg;
    logic [afr_pkg::GAIN_W-1:0] q0;
    logic [X_W-1:0]             rem;
    logic [afr_pkg::GAIN_W-1:0] gain_reg, gain_next;

    always_comb begin
        vol_cap = (aclk_vol_unused_guard > afr_pkg::VOL_W'(afr_pkg::VOL_MAX))
                ? afr_pkg::VOL_W'(afr_pkg::VOL_MAX) : aclk_vol_unused_guard;
        x       = X_W'(vol_cap) * X_W'(afr_pkg::GAIN_NUM);
        q0      = prod_reg[RECIP_SH +: afr_pkg::GAIN_W];
        rem     = x_reg - X_W'(q0) * X_W'(afr_pkg::GAIN_DEN);
        gain_next = (rem >= X_W'(afr_pkg::GAIN_DEN)) ? q0 + afr_pkg::GAIN_W'(1) : q0;
        gain    = gain_reg;
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x;
        prod_reg <= P_W'(x) * P_W'(RECIP);
        gain_reg <= gain_next;
    end

endmodule

`default_nettype wire

FILE: sv/afr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_back #(
    parameter int FIFO_DEPTH = afr_pkg::FIFO_DEPTH_DEF,
    parameter int BURST      = afr_pkg::BURST_DEF,
    parameter int DAC_BITS   = afr_pkg::DAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  afr_pkg::cfg_t                            cfg,
    input  wire logic                                period_load,
    input  wire logic [afr_pkg::PERIOD_W-1:0]        period_value,
    input  wire logic [afr_pkg::GAIN_W-1:0]          gain,
    input  afr_pkg::hs_t                             cmd_hs,
    output logic                                     cmd_ready,
    input  afr_pkg::cmd_t                            cmd,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [DAC_BITS-1:0]                      m_dac_value,
    output logic [afr_pkg::PERIOD_W-1:0]             m_reload_period,
    output logic                                     m_underrun,
    output logic                                     m_last,
    output logic [afr_pkg::FILL_W-1:0]               m_fill_samples,
    output logic [afr_pkg::TOTAL_W-1:0]              m_clip_low_count,
    output logic [afr_pkg::TOTAL_W-1:0]              m_clip_high_count,
    output logic [afr_pkg::TOTAL_W-1:0]              m_underrun_count,
    output logic [afr_pkg::TOTAL_W-1:0]              m_overflow_count
);

    localparam int AW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW      = $clog2(FIFO_DEPTH + 1);
    localparam int BW      = $clog2(BURST + 1);
    localparam int IW      = (BURST > 1) ? $clog2(BURST) : 1;
    localparam int POP_MIN = 4 * BURST;
    localparam int SH      = $clog2(afr_pkg::GAIN_NUM) + afr_pkg::SAMPLE_W - DAC_BITS;
    localparam int PROD_W  = afr_pkg::SAMPLE_W + afr_pkg::GAIN_W + 1;
    localparam int WM_W    = 24;
    localparam int DAC_MAX = (1 << DAC_BITS) - 1;
    localparam int DAC_MID = DAC_MAX / 2;
    localparam int PW      = afr_pkg::PERIOD_W;
    localparam int TW      = afr_pkg::TOTAL_W;

    localparam logic signed [PROD_W-1:0] RND_C = PROD_W'((1 << SH) - 1);
    localparam logic signed [PROD_W-1:0] MID_C = PROD_W'(DAC_MID);
    localparam logic signed [PROD_W-1:0] MAX_C = PROD_W'(DAC_MAX);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRIM  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic signed [afr_pkg::SAMPLE_W-1:0] mem [FIFO_DEPTH];
    logic [DAC_BITS-1:0]                 code_buf [BURST];

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]       count_reg, count_next, fill_reg;
    logic [PW-1:0]       cur_period_reg, cur_period_next;
    logic [DAC_BITS-1:0] last_dac_reg, last_dac_next;
    logic                dropped_reg, dropped_next;
    logic [TW-1:0]       clip_lo_reg, clip_lo_next, clip_hi_reg, clip_hi_next;
    logic [TW-1:0]       und_tot_reg, und_tot_next, ovf_tot_reg, ovf_tot_next;
    logic                und_reg, und_next;
    logic [BW-1:0]       issue_cnt_reg, issue_cnt_next, done_cnt_reg, done_cnt_next;
    logic [BW-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                p1_vld_reg, p2_vld_reg;
    logic                m_valid_reg, m_valid_next;

    logic                lt_vl_reg, lt_lo_reg, gt_hi_reg, gt_vh_reg;
    logic                lt_vl, lt_lo, gt_hi, gt_vh;
    logic [afr_pkg::BYTES_W-1:0] bb_sat;
    logic [WM_W-1:0]     len, bbw;
    logic [PW-1:0]       p_vl, p_lo, p_hi, p_vh, p_sel;

    logic signed [afr_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic signed [PROD_W-1:0]            prod_reg, biased, scaled;
    logic                                clip_lo, clip_hi;
    logic [DAC_BITS-1:0]                 code;

    logic take, push_take, refill_take, fifo_full, do_write, drop_now, out_load, pop_issue;

    logic [DAC_BITS-1:0]         m_dac_reg;
    logic [PW-1:0]               m_period_reg;
    logic                        m_und_reg, m_last_reg;
    logic [afr_pkg::FILL_W-1:0]  m_fill_reg;
    logic [TW-1:0]               m_clo_reg, m_chi_reg, m_utot_reg, m_otot_reg;

    always_comb begin
        cmd_ready   = (state_reg == S_IDLE);
        take        = cmd_hs.valid && cmd_ready;
        push_take   = take && !cmd.is_refill;
        refill_take = take && cmd.is_refill;
        fifo_full   = (count_reg == CW'(FIFO_DEPTH));
        do_write    = push_take && !fifo_full;
        drop_now    = push_take && fifo_full;
        pop_issue   = (state_reg == S_POP);
        out_load    = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

        // Watermark tests: len < floor(bb*k/100) is (len+1)*100 <= bb*k, and
        // len > floor(bb*k/100) is len*100 > bb*k.
        if (cfg.buffer_bytes < afr_pkg::BYTES_W'(afr_pkg::BYTES_MIN)) begin
            bb_sat = afr_pkg::BYTES_W'(afr_pkg::BYTES_MIN);
        end else if (cfg.buffer_bytes > afr_pkg::BYTES_W'(afr_pkg::BYTES_MAX)) begin
            bb_sat = afr_pkg::BYTES_W'(afr_pkg::BYTES_MAX);
        end else begin
            bb_sat = cfg.buffer_bytes;
        end
        len   = WM_W'(count_reg) << 1;
        bbw   = WM_W'(bb_sat);
        lt_vl = (len + WM_W'(1)) * WM_W'(afr_pkg::WM_DEN) <= bbw * WM_W'(afr_pkg::WM_VL);
        lt_lo = (len + WM_W'(1)) * WM_W'(afr_pkg::WM_DEN) <= bbw * WM_W'(afr_pkg::WM_LO);
        gt_vh = len * WM_W'(afr_pkg::WM_DEN) > bbw * WM_W'(afr_pkg::WM_VH);
        gt_hi = len * WM_W'(afr_pkg::WM_DEN) > bbw * WM_W'(afr_pkg::WM_HI);

        p_vl = cfg.nominal_period + PW'(cfg.very_low_offset);
        p_lo = cfg.nominal_period + PW'(cfg.low_offset);
        p_hi = cfg.nominal_period + PW'(cfg.high_offset);
        p_vh = cfg.nominal_period + PW'(cfg.very_high_offset);
        if (lt_vl_reg) begin
            p_sel = p_vl;
        end else if (lt_lo_reg && cur_period_reg != p_vl) begin
            p_sel = p_lo;
        end else if (gt_vh_reg) begin
            p_sel = p_vh;
        end else if (gt_hi_reg && cur_period_reg != p_vh) begin
            p_sel = p_hi;
        end else begin
            p_sel = cur_period_reg;
        end

        biased  = (prod_reg < 0) ? prod_reg + RND_C : prod_reg;
        scaled  = (biased >>> SH) + MID_C;
        clip_lo = (scaled < 0);
        clip_hi = (scaled > MAX_C);
        if (clip_lo) begin
            code = '0;
        end else if (clip_hi) begin
            code = DAC_BITS'(DAC_MAX);
        end else begin
            code = scaled[DAC_BITS-1:0];
        end

        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        cur_period_next = cur_period_reg;
        last_dac_next   = last_dac_reg;
        dropped_next    = dropped_reg;
        clip_lo_next    = clip_lo_reg;
        clip_hi_next    = clip_hi_reg;
        und_tot_next    = und_tot_reg;
        ovf_tot_next    = ovf_tot_reg;
        und_next        = und_reg;
        issue_cnt_next  = issue_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;

        if (p2_vld_reg) begin
            last_dac_next = code;
            done_cnt_next = done_cnt_reg + BW'(1);
            if (clip_lo) begin
                clip_lo_next = clip_lo_reg + TW'(1);
            end
            if (clip_hi) begin
                clip_hi_next = clip_hi_reg + TW'(1);
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (do_write) begin
                    wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1))
                                ? '0 : wr_ptr_reg + AW'(1);
                    count_next  = count_reg + CW'(1);
                end
                if (push_take && cmd.message_end && (dropped_reg || drop_now)) begin
                    ovf_tot_next = ovf_tot_reg + TW'(1);
                    dropped_next = 1'b0;
                end else if (drop_now) begin
                    dropped_next = 1'b1;
                end
                if (refill_take) begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                if (!cfg.correction_off) begin
                    cur_period_next = p_sel;
                end
                issue_cnt_next = '0;
                done_cnt_next  = '0;
                emit_cnt_next  = '0;
                if (fill_reg > CW'(POP_MIN)) begin
                    und_next   = 1'b0;
                    state_next = S_POP;
                end else begin
                    und_next     = 1'b1;
                    und_tot_next = und_tot_reg + TW'(1);
                    state_next   = S_EMIT;
                end
            end
            S_POP: begin
                rd_ptr_next    = (rd_ptr_reg == AW'(FIFO_DEPTH - 1))
                               ? '0 : rd_ptr_reg + AW'(1);
                count_next     = count_reg - CW'(1);
                issue_cnt_next = issue_cnt_reg + BW'(1);
                if (issue_cnt_reg == BW'(BURST - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (done_cnt_reg == BW'(BURST)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    emit_cnt_next = emit_cnt_reg + BW'(1);
                    if (emit_cnt_reg == BW'(BURST - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (period_load) begin
            cur_period_next = period_value;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        m_valid           = m_valid_reg;
        m_dac_value       = m_dac_reg;
        m_reload_period   = m_period_reg;
        m_underrun        = m_und_reg;
        m_last            = m_last_reg;
        m_fill_samples    = m_fill_reg;
        m_clip_low_count  = m_clo_reg;
        m_clip_high_count = m_chi_reg;
        m_underrun_count  = m_utot_reg;
        m_overflow_count  = m_otot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            cur_period_reg <= afr_pkg::NOMINAL_PERIOD_RST;
            last_dac_reg   <= DAC_BITS'(afr_pkg::LAST_DAC_RST & DAC_MAX);
            dropped_reg    <= 1'b0;
            clip_lo_reg    <= '0;
            clip_hi_reg    <= '0;
            und_tot_reg    <= '0;
            ovf_tot_reg    <= '0;
            und_reg        <= 1'b0;
            issue_cnt_reg  <= '0;
            done_cnt_reg   <= '0;
            emit_cnt_reg   <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            cur_period_reg <= cur_period_next;
            last_dac_reg   <= last_dac_next;
            dropped_reg    <= dropped_next;
            clip_lo_reg    <= clip_lo_next;
            clip_hi_reg    <= clip_hi_next;
            und_tot_reg    <= und_tot_next;
            ovf_tot_reg    <= ovf_tot_next;
            und_reg        <= und_next;
            issue_cnt_reg  <= issue_cnt_next;
            done_cnt_reg   <= done_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            p1_vld_reg     <= pop_issue;
            p2_vld_reg     <= p1_vld_reg;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_ptr_reg] <= cmd.sample;
        end
        if (pop_issue) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(rd_data_reg) * $signed({1'b0, gain});
        if (refill_take) begin
            fill_reg  <= count_reg;
            lt_vl_reg <= lt_vl;
            lt_lo_reg <= lt_lo;
            gt_hi_reg <= gt_hi;
            gt_vh_reg <= gt_vh;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_vld_reg) begin
            code_buf[done_cnt_reg[IW-1:0]] <= code;
        end
        if (out_load) begin
            m_dac_reg    <= und_reg ? last_dac_reg : code_buf[emit_cnt_reg[IW-1:0]];
            m_period_reg <= cur_period_reg;
            m_und_reg    <= und_reg;
            m_last_reg   <= (emit_cnt_reg == BW'(BURST - 1));
            m_fill_reg   <= afr_pkg::FILL_W'(fill_reg);
            m_clo_reg    <= clip_lo_reg;
            m_chi_reg    <= clip_hi_reg;
            m_utot_reg   <= und_tot_reg;
            m_otot_reg   <= ovf_tot_reg;
        end
    end

endmodule

`default_nettype wire
